/* rtl/core/utf8_sanitizer_with_limits_core_macros.svh */
// Assertion helpers used by the checker file.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef UTF8_SANITIZER_WITH_LIMITS_CORE_MACROS_SVH
`define UTF8_SANITIZER_WITH_LIMITS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define U8SAN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define U8SAN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/u8san_pkg.sv */
`timescale 1ns / 1ps

package u8san_pkg;

    // Register indexes on the configuration port
    localparam logic REG_MAX_OUT_BYTES   = 1'b0;
    localparam logic REG_MAX_CODE_POINTS = 1'b1;

    localparam logic [15:0] MAX_OUT_BYTES_RST   = 16'd4096;
    localparam logic [15:0] MAX_CODE_POINTS_RST = 16'd1024;

    // Replacement character U+FFFD
    localparam logic [7:0] REPL_B0  = 8'hEF;
    localparam logic [7:0] REPL_B1  = 8'hBF;
    localparam logic [7:0] REPL_B2  = 8'hBD;
    localparam logic [2:0] REPL_LEN = 3'd3;

    // Lead byte classes
    localparam logic [7:0] MASK_2 = 8'hE0;
    localparam logic [7:0] TAG_2  = 8'hC0;
    localparam logic [7:0] MASK_3 = 8'hF0;
    localparam logic [7:0] TAG_3  = 8'hE0;
    localparam logic [7:0] MASK_4 = 8'hF8;
    localparam logic [7:0] TAG_4  = 8'hF0;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Code point bounds
    localparam logic [20:0] CP_MIN_2   = 21'h00080;
    localparam logic [20:0] CP_MIN_3   = 21'h00800;
    localparam logic [20:0] CP_MIN_4   = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST = 21'h0D800;
    localparam logic [20:0] SURR_LAST  = 21'h0DFFF;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take the input transfer into the pending buffer
        logic stop;       // limit hit: stop output, drop pending bytes
        logic rep_skip;   // replacement that does not fit: count only, drop one byte
        logic start_rep;  // begin emitting a replacement
        logic start_seq;  // begin emitting a valid sequence
        logic emit_byte;  // load one byte into the output register
        logic close;      // load the closing item, clear per-string state
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic stopped;
        logic fin;
        logic limit_hit;
        logic incomplete;
        logic bad;
        logic rep_fits;
        logic seq_fits;
        logic out_free;
        logic emit_last;
    } dp_status_t;

    // Sequence length implied by a lead byte, 0 if it cannot lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (!b[7])
            len = 3'd1;
        else if ((b & MASK_2) == TAG_2)
            len = 3'd2;
        else if ((b & MASK_3) == TAG_3)
            len = 3'd3;
        else if ((b & MASK_4) == TAG_4)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Continuation, overlong, surrogate and range checks
    function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic [2:0] len);
        logic [20:0] cp;
        logic        ok;
        cp = '0;
        ok = 1'b1;
        case (len)
            3'd2:
            begin
                cp = {10'd0, b0[4:0], b1[5:0]};
                ok = is_cont(b1) && (cp >= CP_MIN_2);
            end
            3'd3:
            begin
                cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                ok = is_cont(b1) && is_cont(b2) && (cp >= CP_MIN_3);
            end
            3'd4:
            begin
                cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                ok = is_cont(b1) && is_cont(b2) && is_cont(b3) && (cp >= CP_MIN_4);
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase
        if (cp > CP_MAX)
            ok = 1'b0;
        if ((cp >= SURR_FIRST) && (cp <= SURR_LAST))
            ok = 1'b0;
        return ok;
    endfunction

endpackage

/* rtl/core/utf8_sanitizer_with_limits_core.sv */
`timescale 1ns / 1ps

// UTF-8 sanitizer with byte and code point limits. Each accepted input transfer
// carries at most one byte of a string; results are sanitized bytes, one per
// output transfer, and one closing transfer per string carrying the replaced
// and truncated flags. Each item passes through the scan/emit loop of the
// controller; bytes leave through the single output register, which moves one
// byte per cycle while the output is not stalled. Limits are written through the
// APB port (offset 0x0 max_out_bytes, 0x4 max_code_points); the user must write
// them between strings, and the block itself does not enforce this. No clearing
// pass after reset.
module utf8_sanitizer_with_limits_core
    import u8san_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        has_byte,
    input  logic [7:0]  in_byte,
    input  logic        end_of_string,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        ends_code_point,
    output logic        closing,
    output logic        replaced_invalid,
    output logic        truncated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] max_out_bytes;
    logic [15:0] max_code_points;
    ctrl_cmd_t   cmd;
    dp_status_t  status;

    u8san_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .max_out_bytes   (max_out_bytes),
        .max_code_points (max_code_points)
    );

    u8san_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    u8san_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .has_byte         (has_byte),
        .in_byte          (in_byte),
        .end_of_string    (end_of_string),
        .max_out_bytes    (max_out_bytes),
        .max_code_points  (max_code_points),
        .cmd              (cmd),
        .status           (status),
        .result_ready     (result_ready),
        .result_valid     (result_valid),
        .out_valid        (out_valid),
        .out_byte         (out_byte),
        .ends_code_point  (ends_code_point),
        .closing          (closing),
        .replaced_invalid (replaced_invalid),
        .truncated        (truncated)
    );

endmodule

/* rtl/core/u8san_regs.sv */
`timescale 1ns / 1ps

module u8san_regs
    import u8san_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] max_out_bytes,
    output logic [15:0] max_code_points
);

    logic [15:0] max_out_bytes_reg;
    logic [15:0] max_code_points_reg;
    logic        wr_en;
    logic [1:0]  unused_low;

    assign wr_en      = psel && penable && pwrite;
    assign pready     = 1'b1;
    // Byte offset within a word is ignored
    assign unused_low = paddr[1:0];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_out_bytes_reg   <= MAX_OUT_BYTES_RST;
            max_code_points_reg <= MAX_CODE_POINTS_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MAX_OUT_BYTES:   max_out_bytes_reg   <= pwdata[15:0];
                REG_MAX_CODE_POINTS: max_code_points_reg <= pwdata[15:0];
                default:             max_out_bytes_reg   <= max_out_bytes_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_MAX_OUT_BYTES:   prdata = {16'd0, max_out_bytes_reg};
            REG_MAX_CODE_POINTS: prdata = {16'd0, max_code_points_reg};
            default:             prdata = {30'd0, unused_low};
        endcase
    end

    assign max_out_bytes   = max_out_bytes_reg;
    assign max_code_points = max_code_points_reg;

endmodule

/* rtl/core/u8san_ctrl.sv */
`timescale 1ns / 1ps

module u8san_ctrl
    import u8san_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_EMIT  = 4'b0100,
        S_CLOSE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.stopped || status.cnt_zero)
                    state_next = status.fin ? S_CLOSE : S_IDLE;
                else if (status.limit_hit)
                    cmd.stop = 1'b1;
                else if (status.incomplete && !status.fin)
                    state_next = S_IDLE;
                else if (status.bad)
                begin
                    if (status.rep_fits)
                    begin
                        cmd.start_rep = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                        cmd.rep_skip = 1'b1;
                end
                else if (!status.seq_fits)
                    cmd.stop = 1'b1;
                else
                begin
                    cmd.start_seq = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    if (status.emit_last)
                        state_next = S_SCAN;
                end
            end
            S_CLOSE:
            begin
                if (status.out_free)
                begin
                    cmd.close  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/u8san_dp.sv */
`timescale 1ns / 1ps

module u8san_dp
    import u8san_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        has_byte,
    input  logic [7:0]  in_byte,
    input  logic        end_of_string,
    input  logic [15:0] max_out_bytes,
    input  logic [15:0] max_code_points,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic        result_ready,
    output logic        result_valid,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        ends_code_point,
    output logic        closing,
    output logic        replaced_invalid,
    output logic        truncated
);

    // Pending buffer: three held bytes plus the incoming one
    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] obc_reg, obc_next;
    logic [15:0] cpc_reg, cpc_next;
    logic        replaced_reg, replaced_next;
    logic        stopped_reg, stopped_next;
    logic        trunc_reg, trunc_next;
    logic        fin_reg, fin_next;

    // Emit sequencer
    logic        emit_rep_reg, emit_rep_next;
    logic [1:0]  emit_last_reg, emit_last_next;
    logic [1:0]  emit_idx_reg, emit_idx_next;

    // Output register
    logic        res_valid_reg, res_valid_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        ends_reg;
    logic        closing_reg;
    logic        rep_out_reg;
    logic        trunc_out_reg;

    logic [2:0]  lead;
    logic        cnt_lt_lead;
    logic        emit_last_hit;
    logic        out_free;
    logic [7:0]  emit_data;
    logic        do_shift;
    logic [2:0]  shift_amt;
    logic [2:0]  src;

    // Head-of-buffer checks
    assign lead          = lead_length(buf_reg[0]);
    assign cnt_lt_lead   = cnt_reg < lead;
    assign emit_last_hit = emit_idx_reg == emit_last_reg;
    assign out_free      = !res_valid_reg || result_ready;

    assign status.cnt_zero   = cnt_reg == 3'd0;
    assign status.stopped    = stopped_reg;
    assign status.fin        = fin_reg;
    assign status.limit_hit  = (obc_reg >= max_out_bytes) || (cpc_reg >= max_code_points);
    assign status.incomplete = (lead != 3'd0) && cnt_lt_lead;
    assign status.bad        = (lead == 3'd0) || cnt_lt_lead ||
                               !seq_ok(buf_reg[0], buf_reg[1], buf_reg[2], buf_reg[3], lead);
    assign status.rep_fits   = ({1'b0, obc_reg} + {14'd0, REPL_LEN}) <= {1'b0, max_out_bytes};
    assign status.seq_fits   = ({1'b0, obc_reg} + {14'd0, lead}) <= {1'b0, max_out_bytes};
    assign status.out_free   = out_free;
    assign status.emit_last  = emit_last_hit;

    // Byte to emit this cycle
    always_comb
    begin
        if (emit_rep_reg)
        begin
            case (emit_idx_reg)
                2'd0:    emit_data = REPL_B0;
                2'd1:    emit_data = REPL_B1;
                default: emit_data = REPL_B2;
            endcase
        end
        else
            emit_data = buf_reg[emit_idx_reg];
    end

    // A replacement drops one byte, a valid sequence drops its length
    assign do_shift  = cmd.rep_skip || (cmd.emit_byte && emit_last_hit);
    assign shift_amt = (cmd.rep_skip || emit_rep_reg) ? 3'd1 : {1'b0, emit_last_reg} + 3'd1;

    // Buffer and per-string state
    always_comb
    begin
        src            = '0;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        obc_next       = obc_reg;
        cpc_next       = cpc_reg;
        replaced_next  = replaced_reg;
        stopped_next   = stopped_reg;
        trunc_next     = trunc_reg;
        fin_next       = fin_reg;
        emit_rep_next  = emit_rep_reg;
        emit_last_next = emit_last_reg;
        emit_idx_next  = emit_idx_reg;

        if (cmd.load)
        begin
            fin_next = end_of_string;
            if (has_byte)
            begin
                if (stopped_reg)
                    trunc_next = 1'b1;
                else
                begin
                    buf_next[cnt_reg[1:0]] = in_byte;
                    cnt_next               = cnt_reg + 3'd1;
                end
            end
        end

        if (do_shift)
        begin
            for (int i = 0; i < 4; i++)
            begin
                src = 3'(i) + shift_amt;
                if (src < 3'd4)
                    buf_next[i] = buf_reg[src[1:0]];
            end
            cnt_next = cnt_reg - shift_amt;
        end

        if (cmd.stop)
        begin
            stopped_next = 1'b1;
            trunc_next   = 1'b1;
            cnt_next     = 3'd0;
        end

        if (cmd.rep_skip)
        begin
            cpc_next      = cpc_reg + 16'd1;
            replaced_next = 1'b1;
        end

        if (cmd.start_rep)
        begin
            obc_next       = obc_reg + {13'd0, REPL_LEN};
            cpc_next       = cpc_reg + 16'd1;
            replaced_next  = 1'b1;
            emit_rep_next  = 1'b1;
            emit_last_next = 2'(REPL_LEN - 3'd1);
            emit_idx_next  = 2'd0;
        end

        if (cmd.start_seq)
        begin
            obc_next       = obc_reg + {13'd0, lead};
            cpc_next       = cpc_reg + 16'd1;
            emit_rep_next  = 1'b0;
            emit_last_next = 2'(lead - 3'd1);
            emit_idx_next  = 2'd0;
        end

        if (cmd.emit_byte)
            emit_idx_next = emit_idx_reg + 2'd1;

        if (cmd.close)
        begin
            cnt_next      = 3'd0;
            obc_next      = 16'd0;
            cpc_next      = 16'd0;
            replaced_next = 1'b0;
            stopped_next  = 1'b0;
            trunc_next    = 1'b0;
            fin_next      = 1'b0;
        end
    end

    // Output handshake
    always_comb
    begin
        if (cmd.emit_byte || cmd.close)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            obc_reg       <= '0;
            cpc_reg       <= '0;
            replaced_reg  <= 1'b0;
            stopped_reg   <= 1'b0;
            trunc_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            emit_rep_reg  <= 1'b0;
            emit_last_reg <= '0;
            emit_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            obc_reg       <= obc_next;
            cpc_reg       <= cpc_next;
            replaced_reg  <= replaced_next;
            stopped_reg   <= stopped_next;
            trunc_reg     <= trunc_next;
            fin_reg       <= fin_next;
            emit_rep_reg  <= emit_rep_next;
            emit_last_reg <= emit_last_next;
            emit_idx_reg  <= emit_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        if (cmd.emit_byte)
        begin
            out_valid_reg <= 1'b1;
            out_byte_reg  <= emit_data;
            ends_reg      <= emit_last_hit;
            closing_reg   <= 1'b0;
            rep_out_reg   <= 1'b0;
            trunc_out_reg <= 1'b0;
        end
        else if (cmd.close)
        begin
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            ends_reg      <= 1'b0;
            closing_reg   <= 1'b1;
            rep_out_reg   <= replaced_reg;
            trunc_out_reg <= trunc_reg;
        end
    end

    assign result_valid     = res_valid_reg;
    assign out_valid        = out_valid_reg;
    assign out_byte         = out_byte_reg;
    assign ends_code_point  = ends_reg;
    assign closing          = closing_reg;
    assign replaced_invalid = rep_out_reg;
    assign truncated        = trunc_out_reg;

endmodule

/* rtl/core/u8san_checker.sv */
`timescale 1ns / 1ps
`include "utf8_sanitizer_with_limits_core_macros.svh"

module u8san_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       result_valid,
    input logic       out_valid,
    input logic [7:0] out_byte,
    input logic       ends_code_point,
    input logic       closing,
    input logic       replaced_invalid,
    input logic       truncated,
    input logic       pready
);

    // Closing transfer carries no byte
    `U8SAN_ASSERT_SAME(a_close_no_byte, result_valid && closing, !out_valid && (out_byte == 8'd0) && !ends_code_point, "closing transfer carries a byte")

    // Byte transfers carry no string flags
    `U8SAN_ASSERT_SAME(a_byte_no_flags, result_valid && !closing, out_valid && !replaced_invalid && !truncated && pready, "byte transfer carries status flags")

    // Last byte of a code point is ASCII or a continuation byte
    `U8SAN_ASSERT_SAME(a_end_byte_class, result_valid && out_valid && ends_code_point, out_byte[7:6] != 2'b11, "code point ends on a lead byte")

    // Block is busy in the cycle after taking an input transfer
    `U8SAN_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready, "input taken while previous item in flight")

endmodule

bind utf8_sanitizer_with_limits_core u8san_checker u_u8san_checker (.*);
